// ----- hdl/pcmea_pkg.sv -----
package pcmea_pkg;

    // Wide enough for every count and bound in the supported parameter range
    localparam int CMP_W = 14;

    typedef enum logic [2:0] {
        ST_GRANTED = 3'd0,
        ST_HEAP    = 3'd1,
        ST_DROPPED = 3'd2,
        ST_STORED  = 3'd3,
        ST_RELEASE = 3'd4,
        ST_IDLE    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC     = 2'd0,
        OP_ALLOC_IRQ = 2'd1,
        OP_FREE      = 2'd2,
        OP_TRIM      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_CAPACITY = 2'd0,
        CFG_BATCH    = 2'd1,
        CFG_LIMIT    = 2'd2,
        CFG_UNUSED   = 2'd3
    } t_cfg_index;

    localparam logic [6:0] CAPACITY_RESET = 7'd64;
    localparam logic [5:0] BATCH_RESET    = 6'd32;
    localparam logic [8:0] LIMIT_RESET    = 9'd256;

endpackage

// ----- hdl/pcmea_ram.sv -----
module pcmea_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/per_cpu_magazine_entry_allocator.sv -----
// Path to o_valid: a magazine hit passes S_DECIDE, S_MPOP and S_MPOP_WAIT; an interrupt
// pool request S_IRQ_WAIT; a trim step S_TRIM_WAIT; a free that stores directly S_MPUSH;
// an interrupt handle free goes from S_DECIDE to S_OUT. An allocate on an empty magazine
// refills via S_RF and S_RF_WR (or answers use heap); a spill moves via S_SP and S_SP_WR.
// Throughput: one request at a time; o_stall stays high until the result is taken.
// Reset: synchronous, active low; counts clear, the interrupt stack reads as 0..N-1
// with 0 on top, registers take their reset values, and no clearing pass is needed.
module per_cpu_magazine_entry_allocator
    import pcmea_pkg::*;
#(
    parameter int NUM_CPUS       = 8,
    parameter int MAGAZINE_DEPTH = 64,
    parameter int DEPOT_DEPTH    = 256,
    parameter int IRQ_POOL_SIZE  = 512,
    parameter int HANDLE_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [2:0]  i_cpu,
    input  logic [15:0] i_handle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_handle_out,
    output logic [31:0] o_drop_count,
    output logic        o_more,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int CPU_W  = NUM_CPUS > 1 ? $clog2(NUM_CPUS) : 1;
    localparam int MAG_N  = NUM_CPUS * MAGAZINE_DEPTH;
    localparam int MAG_AW = $clog2(MAG_N > 1 ? MAG_N : 2);
    localparam int MCW    = $clog2(MAGAZINE_DEPTH + 1);
    localparam int DAW    = $clog2(DEPOT_DEPTH > 1 ? DEPOT_DEPTH : 2);
    localparam int DCW    = $clog2(DEPOT_DEPTH + 1);
    localparam int IAW    = $clog2(IRQ_POOL_SIZE > 1 ? IRQ_POOL_SIZE : 2);
    localparam int ICW    = $clog2(IRQ_POOL_SIZE + 1);
    localparam int HW     = HANDLE_BITS < 16 ? HANDLE_BITS : 16;

    typedef enum logic [3:0] {
        S_IDLE, S_DECIDE, S_RF, S_RF_WR, S_MPOP, S_MPOP_WAIT,
        S_SP, S_SP_WR, S_MPUSH, S_IRQ_WAIT, S_TRIM_WAIT, S_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [1:0]          r_op, n_op;
    logic [CPU_W-1:0]    r_cpu, n_cpu;
    logic [HW-1:0]       r_h, n_h;
    logic [MAG_AW-1:0]   r_base, n_base;
    logic [MCW-1:0]      r_mc, n_mc;
    logic [5:0]          r_moved, n_moved;
    logic [DCW-1:0]      r_dc, n_dc;
    logic [ICW-1:0]      r_irq_cnt, n_irq_cnt;
    logic [ICW-1:0]      r_irq_low, n_irq_low;
    logic                r_irq_hit, n_irq_hit;
    logic [IAW-1:0]      r_irq_alt, n_irq_alt;
    logic [31:0]         r_drop, n_drop;
    logic [2:0]          r_status, n_status;
    logic [15:0]         r_hout, n_hout;
    logic                r_more, n_more;
    logic [MCW-1:0]      r_counts [NUM_CPUS];
    logic [6:0]          r_cap;
    logic [5:0]          r_batch;
    logic [8:0]          r_lim;

    logic                mag_we, dep_we, irq_we;
    logic [MAG_AW-1:0]   mag_waddr, mag_raddr;
    logic [HW-1:0]       mag_wdata, mag_rdata;
    logic [DAW-1:0]      dep_waddr, dep_raddr;
    logic [HW-1:0]       dep_wdata, dep_rdata;
    logic [IAW-1:0]      irq_waddr, irq_raddr;
    logic [IAW-1:0]      irq_wdata, irq_rdata;

    logic [CMP_W-1:0]    x_cap, x_lim, x_batch, x_mc, x_dc;
    logic [CPU_W-1:0]    cpu_m;
    logic [ICW-1:0]      irq_top;

    function automatic logic [2:0] f_cpu_mod(input logic [2:0] v);
        logic [2:0] r;
        r = v;
        for (int k = 0; k < 8; k++) begin
            if (32'(r) >= NUM_CPUS) begin
                r = 3'(32'(r) - NUM_CPUS);
            end
        end
        return r;
    endfunction

    assign cpu_m = CPU_W'(f_cpu_mod(i_cpu));

    // Clamp capacity and limit to what the storage can hold
    assign x_cap   = (CMP_W'(r_cap) > CMP_W'(MAGAZINE_DEPTH)) ? CMP_W'(MAGAZINE_DEPTH)
                                                               : CMP_W'(r_cap);
    assign x_lim   = (CMP_W'(r_lim) > CMP_W'(DEPOT_DEPTH)) ? CMP_W'(DEPOT_DEPTH)
                                                            : CMP_W'(r_lim);
    assign x_batch = CMP_W'(r_batch);
    assign x_mc    = CMP_W'(r_mc);
    assign x_dc    = CMP_W'(r_dc);
    assign irq_top = r_irq_cnt - ICW'(1);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_cpu     = r_cpu;
        n_h       = r_h;
        n_base    = r_base;
        n_mc      = r_mc;
        n_moved   = r_moved;
        n_dc      = r_dc;
        n_irq_cnt = r_irq_cnt;
        n_irq_low = r_irq_low;
        n_irq_hit = r_irq_hit;
        n_irq_alt = r_irq_alt;
        n_drop    = r_drop;
        n_status  = r_status;
        n_hout    = r_hout;
        n_more    = r_more;
        mag_we    = 1'b0;
        mag_waddr = r_base + MAG_AW'(r_mc);
        mag_wdata = r_h;
        mag_raddr = r_base + MAG_AW'(r_mc - MCW'(1));
        dep_we    = 1'b0;
        dep_waddr = DAW'(r_dc);
        dep_wdata = mag_rdata;
        dep_raddr = DAW'(r_dc - DCW'(1));
        irq_we    = 1'b0;
        irq_waddr = IAW'(r_irq_cnt);
        irq_wdata = IAW'(r_h);
        irq_raddr = IAW'(irq_top);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op    = i_operation;
                    n_cpu   = cpu_m;
                    n_h     = HW'(i_handle & 16'(32'hFFFF_FFFF >> (32 - HANDLE_BITS)));
                    n_base  = MAG_AW'(32'(cpu_m) * MAGAZINE_DEPTH);
                    n_mc    = r_counts[cpu_m];
                    n_moved = '0;
                    n_hout  = '0;
                    n_more  = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                unique case (t_op'(r_op))
                    OP_ALLOC: begin
                        n_state = (r_mc == '0) ? S_RF : S_MPOP;
                    end
                    OP_ALLOC_IRQ: begin
                        if (r_irq_cnt != '0) begin
                            // Entries below the lowest push were never written; their value is computed, not read
                            n_irq_cnt = irq_top;
                            n_irq_hit = irq_top >= r_irq_low;
                            n_irq_alt = IAW'(ICW'(IRQ_POOL_SIZE - 1) - irq_top);
                            n_state   = S_IRQ_WAIT;
                        end else begin
                            n_drop   = r_drop + 32'd1;
                            n_status = ST_DROPPED;
                            n_state  = S_OUT;
                        end
                    end
                    OP_FREE: begin
                        if (32'(r_h) < IRQ_POOL_SIZE) begin
                            if (32'(r_irq_cnt) < IRQ_POOL_SIZE) begin
                                irq_we    = 1'b1;
                                n_irq_cnt = r_irq_cnt + ICW'(1);
                                if (r_irq_cnt < r_irq_low) begin
                                    n_irq_low = r_irq_cnt;
                                end
                                n_status  = ST_STORED;
                            end else begin
                                n_status  = ST_DROPPED;
                            end
                            n_state = S_OUT;
                        end else begin
                            n_state = (x_mc >= x_cap) ? S_SP : S_MPUSH;
                        end
                    end
                    default: begin
                        if (x_dc > x_batch) begin
                            n_dc    = r_dc - DCW'(1);
                            n_state = S_TRIM_WAIT;
                        end else begin
                            n_status = ST_IDLE;
                            n_state  = S_OUT;
                        end
                    end
                endcase
            end
            S_RF: begin
                if (CMP_W'(r_moved) < x_batch && r_dc != '0 && x_mc < x_cap) begin
                    n_dc    = r_dc - DCW'(1);
                    n_moved = r_moved + 6'd1;
                    n_state = S_RF_WR;
                end else if (r_mc != '0) begin
                    n_state = S_MPOP;
                end else begin
                    n_status = ST_HEAP;
                    n_state  = S_OUT;
                end
            end
            S_RF_WR: begin
                mag_we    = 1'b1;
                mag_wdata = dep_rdata;
                n_mc      = r_mc + MCW'(1);
                n_state   = S_RF;
            end
            S_MPOP: begin
                n_mc    = r_mc - MCW'(1);
                n_state = S_MPOP_WAIT;
            end
            S_MPOP_WAIT: begin
                n_hout   = 16'(mag_rdata);
                n_status = ST_GRANTED;
                n_state  = S_OUT;
            end
            S_SP: begin
                if (CMP_W'(r_moved) < x_batch && x_dc < x_lim && r_mc != '0) begin
                    n_mc    = r_mc - MCW'(1);
                    n_moved = r_moved + 6'd1;
                    n_state = S_SP_WR;
                end else begin
                    n_state = S_MPUSH;
                end
            end
            S_SP_WR: begin
                dep_we  = 1'b1;
                n_dc    = r_dc + DCW'(1);
                n_state = S_SP;
            end
            S_MPUSH: begin
                if (x_mc < x_cap) begin
                    mag_we   = 1'b1;
                    n_mc     = r_mc + MCW'(1);
                    n_status = ST_STORED;
                end else begin
                    n_status = ST_RELEASE;
                    n_hout   = 16'(r_h);
                end
                n_state = S_OUT;
            end
            S_IRQ_WAIT: begin
                n_hout   = r_irq_hit ? 16'(irq_rdata) : 16'(r_irq_alt);
                n_status = ST_GRANTED;
                n_state  = S_OUT;
            end
            S_TRIM_WAIT: begin
                n_hout   = 16'(dep_rdata);
                n_status = ST_RELEASE;
                n_more   = x_dc > x_batch;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_dc      <= '0;
            r_irq_cnt <= ICW'(IRQ_POOL_SIZE);
            r_irq_low <= ICW'(IRQ_POOL_SIZE);
            r_drop    <= '0;
            r_cap     <= CAPACITY_RESET;
            r_batch   <= BATCH_RESET;
            r_lim     <= LIMIT_RESET;
            for (int i = 0; i < NUM_CPUS; i++) begin
                r_counts[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_dc      <= n_dc;
            r_irq_cnt <= n_irq_cnt;
            r_irq_low <= n_irq_low;
            r_drop    <= n_drop;
            if (r_state == S_OUT) begin
                r_counts[r_cpu] <= r_mc;
            end
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_CAPACITY: r_cap   <= i_cfg_data[6:0];
                    CFG_BATCH:    r_batch <= i_cfg_data[5:0];
                    CFG_LIMIT:    r_lim   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
        r_op      <= n_op;
        r_cpu     <= n_cpu;
        r_h       <= n_h;
        r_base    <= n_base;
        r_mc      <= n_mc;
        r_moved   <= n_moved;
        r_irq_hit <= n_irq_hit;
        r_irq_alt <= n_irq_alt;
        r_status  <= n_status;
        r_hout    <= n_hout;
        r_more    <= n_more;
    end

    pcmea_ram #(.WIDTH(HW), .DEPTH(MAG_N)) u_mag_ram (
        .i_clk   (i_clk),
        .i_we    (mag_we),
        .i_waddr (mag_waddr),
        .i_wdata (mag_wdata),
        .i_raddr (mag_raddr),
        .o_rdata (mag_rdata)
    );

    pcmea_ram #(.WIDTH(HW), .DEPTH(DEPOT_DEPTH)) u_depot_ram (
        .i_clk   (i_clk),
        .i_we    (dep_we),
        .i_waddr (dep_waddr),
        .i_wdata (dep_wdata),
        .i_raddr (dep_raddr),
        .o_rdata (dep_rdata)
    );

    pcmea_ram #(.WIDTH(IAW), .DEPTH(IRQ_POOL_SIZE)) u_irq_ram (
        .i_clk   (i_clk),
        .i_we    (irq_we),
        .i_waddr (irq_waddr),
        .i_wdata (irq_wdata),
        .i_raddr (irq_raddr),
        .o_rdata (irq_rdata)
    );

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_status     = r_status;
    assign o_handle_out = r_hout;
    assign o_drop_count = r_drop;
    assign o_more       = r_more;
    assign o_cfg_ready  = 1'b1;

endmodule

// ----- hdl/pcmea_chk.sv -----
module pcmea_chk
    import pcmea_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [15:0] o_handle_out,
    input logic [31:0] o_drop_count,
    input logic        o_more
);

    // A waiting result blocks new requests
    a_out_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while requests accepted");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block not busy after accepting a request");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_handle_out) &&
                                  $stable(o_drop_count) && $stable(o_more)))
        else $error("stalled result changed");

    a_zero_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_HEAP || o_status == ST_DROPPED ||
                     o_status == ST_STORED || o_status == ST_IDLE)) |-> o_handle_out == '0)
        else $error("handle driven on a result without one");

    a_more_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_more) |-> o_status == ST_RELEASE)
        else $error("more flag without a release");

endmodule

bind per_cpu_magazine_entry_allocator pcmea_chk u_pcmea_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_status     (o_status),
    .o_handle_out (o_handle_out),
    .o_drop_count (o_drop_count),
    .o_more       (o_more)
);
